@@ hdl/wavetable_channel_mixer_assert.svh @@
// ----------------------------------------------------------------------------
// Wavetable channel mixer assertion macros
// Clocked checks on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_CHANNEL_MIXER_ASSERT_SVH
`define WAVETABLE_CHANNEL_MIXER_ASSERT_SVH

// Same-cycle implication.
`define WCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Wavetable channel mixer package
// Field widths, request and register codes, and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wcm_pkg;

    localparam int REQ_W      = 2;
    localparam int CH_W       = 2;
    localparam int FREQ_W     = 16;
    localparam int TIDX_W     = 13;
    localparam int TVAL_W     = 8;
    localparam int SAMPLE_W   = 15;
    localparam int RATE_W     = 18;
    localparam int TLEN_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // freq_hz * 25 fits in this many bits
    localparam int HZ25_W   = FREQ_W + 5;
    localparam int RATE_MUL = 25;
    localparam int OUT_SHIFT = 7;

    localparam logic [TVAL_W-1:0] MIX_MID  = 8'd127;
    localparam logic [TVAL_W-1:0] TVAL_NEG = 8'h80;
    localparam logic [TVAL_W-1:0] TVAL_SAT = 8'h81;

    localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_FREQ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SILENCE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RENDER   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MUTED        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
    localparam logic [TLEN_W-1:0] TLEN_RESET = 14'd6924;

endpackage

@@ hdl/wavetable_channel_mixer.sv @@
// ----------------------------------------------------------------------------
// Wavetable channel mixer
// Shared signed wavetable read by several phase-accumulator oscillators and
// mixed down to one audio sample per render request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* is a valid/ready request channel. A transfer carries one request:
//   load a table entry, set one channel's frequency, silence all channels or
//   render one sample. Only a render produces a transfer on m_* (m_sample).
//   cfg_wr_en/cfg_index/cfg_wr_data write muted, output rate and table length;
//   write them only while the block is idle.
//   Request handling (s_ready is high only between requests):
//     load, silence : done in S_IDLE as the request is taken.
//     set frequency : runs the bit-serial restoring divider that forms
//                     hz*25*2^F / output rate, then updates the channel.
//     render        : reads the channels through the single read port of
//                     the channel-state memory, one channel per cycle,
//                     then mixes; a muted render skips reads and mix.
//   A rendered sample shows on m_valid from the output state once the
//   output register is free.
//   The result sits in an output register, so the next request is taken
//   while a rendered sample waits; a render that finishes while m_sample is
//   still unclaimed holds until the receiver takes it.
//   Reset: all channels silent, phases zero, default configuration. The
//   wavetable is not cleared; reading an entry never loaded gives garbage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wavetable_channel_mixer_assert.svh"

module wavetable_channel_mixer #(
    parameter int NUM_CHANNELS    = 4,
    parameter int TABLE_DEPTH     = 8192,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [wcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wcm_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [wcm_pkg::REQ_W-1:0]            s_req_type,
    input  logic [wcm_pkg::CH_W-1:0]             s_channel,
    input  logic [wcm_pkg::FREQ_W-1:0]           s_freq_hz,
    input  logic [wcm_pkg::TIDX_W-1:0]           s_table_index,
    input  logic signed [wcm_pkg::TVAL_W-1:0]    s_table_value,
    // sample channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [wcm_pkg::SAMPLE_W-1:0]  m_sample
);

    import wcm_pkg::*;

    // Table address and phase widths. Phase stays below TABLE_DEPTH << F.
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int PW   = AW + PHASE_FRAC_BITS;
    localparam int PW1  = PW + 1;
    localparam int LW   = $clog2(TABLE_DEPTH + 1);
    localparam int CW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    // Divider: numerator hz*25 << F, quotient formed in place.
    localparam int NUMW = HZ25_W + PHASE_FRAC_BITS;
    localparam int DCW  = $clog2(NUMW + 1);
    // Mix sum and exact divide by NUM_CHANNELS through a ceiling reciprocal.
    localparam int SW     = $clog2(NUM_CHANNELS * 254 + 1);
    localparam int MK     = SW + $clog2(NUM_CHANNELS);
    localparam int MK1    = MK + 1;
    localparam int PROD_W = SW + MK1;
    localparam logic [MK:0] MIX_RECIP =
        MK1'(((1 << MK) + NUM_CHANNELS - 1) / NUM_CHANNELS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_SF_RD  = 7'b0000100,
        S_SF_WR  = 7'b0001000,
        S_RENDER = 7'b0010000,
        S_MIX    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic              muted_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [TLEN_W-1:0] tlen_reg;

    // Wrap point derived from table_length, refreshed every cycle
    logic [LW-1:0]  len_eff;
    logic [PW1-1:0] wrap_reg;
    logic [PW-1:0]  wrap_m1_reg;

    // Per-channel flags in flops
    logic [NUM_CHANNELS-1:0] active_reg;
    logic [NUM_CHANNELS-1:0] pvalid_reg;

    // Memories: wavetable and per-channel {phase, step}
    logic [TVAL_W-1:0] tbl_mem [TABLE_DEPTH];
    logic [TVAL_W-1:0] tbl_q;
    logic              tbl_we;
    logic [AW-1:0]     tbl_raddr;
    logic [TVAL_W-1:0] tbl_wdata;

    logic [2*PW-1:0] chm_mem [NUM_CHANNELS];
    logic [2*PW-1:0] chm_q;
    logic            chm_we;
    logic [CW-1:0]   chm_raddr;
    logic [CW-1:0]   chm_waddr;
    logic [2*PW-1:0] chm_wdata;

    // Request latch and divider
    logic [CW-1:0]     ch_reg;
    logic              hz_nz_reg;
    logic [NUMW-1:0]   num_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] div_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic [RATE_W:0]   rem_sh;
    logic              rem_ge;
    logic [RATE_W-1:0] rem_nx;

    // Render pipeline
    logic [CW-1:0] rd_cnt_reg;
    logic          iss_done_reg;
    logic          p1_vld_reg;
    logic          p1_last_reg;
    logic [CW-1:0] p1_ch_reg;
    logic          p2_vld_reg;
    logic          p2_last_reg;
    logic          p2_act_reg;
    logic [SW-1:0] acc_reg;
    logic [TVAL_W-1:0] term;
    logic [PROD_W-1:0] prod;
    logic [TVAL_W-1:0] mix_reg;

    // Phase update
    logic [CW-1:0]  cur_ch;
    logic [PW-1:0]  keep_phase;
    logic [PW-1:0]  cstep;
    logic [PW1-1:0] nsum;
    logic [PW-1:0]  nphase;
    logic [PW-1:0]  sf_step;
    logic           render_wr;

    // Output register
    logic                      m_valid_reg;
    logic [SAMPLE_W-1:0]       m_sample_reg;
    logic [TVAL_W:0]           mix_diff;
    logic                      out_free;

    logic in_xfer;
    logic ch_ok;
    logic idx_ok;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign ch_ok    = (32'(s_channel) < NUM_CHANNELS);
    assign idx_ok   = (32'(s_table_index) < TABLE_DEPTH);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // ------------------------------------------------------------------
    // Effective table length: zero acts as 1, beyond depth acts as depth
    // ------------------------------------------------------------------
    always_comb begin
        if (tlen_reg == '0) begin
            len_eff = LW'(1);
        end else if (32'(tlen_reg) > TABLE_DEPTH) begin
            len_eff = LW'(TABLE_DEPTH);
        end else begin
            len_eff = LW'(tlen_reg);
        end
    end

    always_ff @(posedge aclk) begin
        wrap_reg    <= PW1'(len_eff) << PHASE_FRAC_BITS;
        wrap_m1_reg <= PW'((PW1'(len_eff) << PHASE_FRAC_BITS) - PW1'(1));
    end

    // ------------------------------------------------------------------
    // Divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    always_comb begin
        rem_sh = {rem_reg, num_reg[NUMW-1]};
        rem_ge = (rem_sh >= {1'b0, div_reg});
        rem_nx = rem_ge ? RATE_W'(rem_sh - {1'b0, div_reg}) : RATE_W'(rem_sh);
    end

    // ------------------------------------------------------------------
    // Channel-state read-modify-write. Render touches each channel once
    // (read in one cycle, written back the next), and set frequency reads
    // then writes one entry, so no two accesses to one entry overlap.
    // ------------------------------------------------------------------
    always_comb begin
        cur_ch     = (state_reg == S_SF_WR) ? ch_reg : p1_ch_reg;
        keep_phase = pvalid_reg[cur_ch] ? chm_q[2*PW-1:PW] : '0;
        cstep      = (chm_q[PW-1:0] > wrap_m1_reg) ? wrap_m1_reg : chm_q[PW-1:0];
        nsum       = PW1'(keep_phase) + PW1'(cstep);
        nphase     = (nsum >= wrap_reg) ? PW'(nsum - wrap_reg) : PW'(nsum);
        sf_step    = (num_reg > NUMW'(wrap_m1_reg)) ? wrap_m1_reg : num_reg[PW-1:0];
        render_wr  = p1_vld_reg && active_reg[p1_ch_reg];

        chm_raddr = (state_reg == S_RENDER) ? rd_cnt_reg : ch_reg;
        chm_we    = render_wr || (state_reg == S_SF_WR);
        chm_waddr = cur_ch;
        // a render writes the step back unclamped; it is clamped again at each render
        chm_wdata = (state_reg == S_SF_WR) ? {keep_phase, sf_step}
                                           : {nphase, chm_q[PW-1:0]};

        tbl_we    = in_xfer && (s_req_type == REQ_LOAD) && idx_ok;
        tbl_wdata = ($unsigned(s_table_value) == TVAL_NEG) ? TVAL_SAT
                                                           : $unsigned(s_table_value);
        tbl_raddr = keep_phase[PW-1:PHASE_FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (chm_we) begin
            chm_mem[chm_waddr] <= chm_wdata;
        end
        chm_q <= chm_mem[chm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[AW'(s_table_index)] <= tbl_wdata;
        end
        tbl_q <= tbl_mem[tbl_raddr];
    end

    // ------------------------------------------------------------------
    // Mix: silent channel adds the midpoint, active one its sample + 127
    // ------------------------------------------------------------------
    always_comb begin
        term     = p2_act_reg ? TVAL_W'(tbl_q + MIX_MID) : MIX_MID;
        prod     = PROD_W'(acc_reg) * PROD_W'(MIX_RECIP);
        mix_diff = {1'b0, mix_reg} - {1'b0, MIX_MID};
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (s_req_type)
                        REQ_SET_FREQ: begin
                            if (ch_ok) begin
                                state_next = S_DIV;
                            end
                        end
                        REQ_RENDER: begin
                            state_next = muted_reg ? S_OUT : S_RENDER;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (dcnt_reg == DCW'(1)) begin
                    state_next = S_SF_RD;
                end
            end
            S_SF_RD:  state_next = S_SF_WR;
            S_SF_WR:  state_next = S_IDLE;
            S_RENDER: begin
                if (p2_vld_reg && p2_last_reg) begin
                    state_next = S_MIX;
                end
            end
            S_MIX:    state_next = S_OUT;
            S_OUT: begin
                // hold the finished sample until the output register frees up
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            muted_reg    <= 1'b0;
            rate_reg     <= RATE_RESET;
            tlen_reg     <= TLEN_RESET;
            active_reg   <= '0;
            pvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            iss_done_reg <= 1'b1;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MUTED:        muted_reg <= cfg_wr_data[0];
                    CFG_OUT_RATE:     rate_reg  <= cfg_wr_data[RATE_W-1:0];
                    CFG_TABLE_LENGTH: tlen_reg  <= cfg_wr_data[TLEN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_xfer && (s_req_type == REQ_SILENCE)) begin
                active_reg <= '0;
            end
            if (state_reg == S_SF_WR) begin
                active_reg[ch_reg] <= hz_nz_reg;
                pvalid_reg[ch_reg] <= 1'b1;
            end

            // issue one channel read per cycle until all are out
            if (in_xfer && (s_req_type == REQ_RENDER)) begin
                iss_done_reg <= 1'b0;
            end else if ((state_reg == S_RENDER) && !iss_done_reg &&
                         (rd_cnt_reg == CW'(NUM_CHANNELS - 1))) begin
                iss_done_reg <= 1'b1;
            end
            p1_vld_reg <= (state_reg == S_RENDER) && !iss_done_reg;
            p2_vld_reg <= p1_vld_reg;

            if ((state_reg == S_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            ch_reg    <= CW'(s_channel);
            hz_nz_reg <= (s_freq_hz != '0);
            num_reg   <= (NUMW'(s_freq_hz) * NUMW'(RATE_MUL)) << PHASE_FRAC_BITS;
            rem_reg   <= '0;
            div_reg   <= (rate_reg == '0) ? RATE_W'(1) : rate_reg;
            dcnt_reg  <= DCW'(NUMW);
        end else if (state_reg == S_DIV) begin
            num_reg  <= {num_reg[NUMW-2:0], rem_ge};
            rem_reg  <= rem_nx;
            dcnt_reg <= dcnt_reg - DCW'(1);
        end

        if (in_xfer) begin
            rd_cnt_reg <= '0;
            acc_reg    <= '0;
        end else begin
            if ((state_reg == S_RENDER) && !iss_done_reg) begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            if (p2_vld_reg) begin
                acc_reg <= acc_reg + SW'(term);
            end
        end

        p1_ch_reg   <= rd_cnt_reg;
        p1_last_reg <= (rd_cnt_reg == CW'(NUM_CHANNELS - 1));
        p2_last_reg <= p1_last_reg;
        p2_act_reg  <= active_reg[p1_ch_reg];

        // a muted render mixes to the midpoint, which comes out as zero
        if (in_xfer) begin
            mix_reg <= MIX_MID;
        end else if (state_reg == S_MIX) begin
            mix_reg <= TVAL_W'(prod >> MK);
        end

        if ((state_reg == S_OUT) && out_free) begin
            m_sample_reg <= SAMPLE_W'(mix_diff) << OUT_SHIFT;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `WCM_ASSERT_NOW(a_div_rem_below_divisor, state_reg == S_DIV, rem_reg < div_reg,
        "divider remainder not below divisor")
    `WCM_ASSERT_NEXT(a_pipe_advances, p1_vld_reg, p2_vld_reg,
        "render pipeline dropped a channel")
    `WCM_ASSERT_NEXT(a_last_channel_mixes, p2_vld_reg && p2_last_reg && state_reg == S_RENDER,
        state_reg == S_MIX, "mix did not follow the last channel")
    `WCM_ASSERT_NEXT(a_out_holds_when_full,
        state_reg == S_OUT && m_valid_reg && !m_ready, state_reg == S_OUT,
        "finished sample left while output register was full")

endmodule
